// File: hw/rtl/swfc_pkg.sv
package swfc_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FIRST_BAD  = 2'd1,
        ST_SECOND_BAD = 2'd2
    } t_frame_status;

    typedef enum logic [2:0] {
        POS_W0_HI  = 3'd0,
        POS_W0_LO  = 3'd1,
        POS_W0_CRC = 3'd2,
        POS_W1_HI  = 3'd3,
        POS_W1_LO  = 3'd4,
        POS_W1_CRC = 3'd5
    } t_byte_pos;

endpackage

// File: hw/rtl/swfc_crc8.sv
module swfc_crc8
    import swfc_pkg::*;
(
    input  logic [BYTE_W-1:0] i_crc,
    input  logic [BYTE_W-1:0] i_byte,
    output logic [BYTE_W-1:0] o_crc
);

    always_comb begin
        logic [BYTE_W-1:0] c;
        c = i_crc ^ i_byte;
        for (int i = 0; i < BYTE_W; i++) begin
            if ((c & CRC_TOP) != '0) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

// File: hw/rtl/sensor_word_frame_checker_core.sv
// An accepted byte lands in the input register; the result register loads
//   when that byte is processed, which waits while a result is held unread.
// Throughput: one byte per cycle while no result is held unread; one result
//   per six-byte frame.
// Reset (synchronous, active low) clears the byte position, the pending and
//   held words and both valid flags, and sets the running CRC to 0xFF.
module sensor_word_frame_checker_core
    import swfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] frame_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] co2_equivalent, [31:16] voc_total
    output logic [1:0]  o_m_axis_tuser    // [1:0] frame_status
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;

    logic [2:0]        r_pos;
    logic [BYTE_W-1:0] r_crc;
    logic [WORD_W-1:0] r_pend0;
    logic [WORD_W-1:0] r_pend1;
    logic              r_first_bad;
    logic [WORD_W-1:0] r_held_co2;
    logic [WORD_W-1:0] r_held_voc;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_co2;
    logic [WORD_W-1:0] r_out_voc;
    t_frame_status     r_out_status;

    logic              advance;
    logic              process;
    logic              in_xfer;
    t_byte_pos         pos;
    logic [BYTE_W-1:0] crc_base;
    logic [BYTE_W-1:0] crc_next;

    logic [2:0]        n_pos;
    logic [BYTE_W-1:0] n_crc;
    logic [WORD_W-1:0] n_pend0;
    logic [WORD_W-1:0] n_pend1;
    logic              n_first_bad;
    logic [WORD_W-1:0] n_held_co2;
    logic [WORD_W-1:0] n_held_voc;
    logic              n_emit;
    t_frame_status     n_status;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign process         = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        if (r_in_start || r_pos > 3'd5) begin
            pos = POS_W0_HI;
        end else begin
            pos = t_byte_pos'(r_pos);
        end
    end

    assign crc_base = (pos == POS_W0_HI || pos == POS_W1_HI) ? CRC_INIT : r_crc;

    swfc_crc8 u_crc (
        .i_crc  (crc_base),
        .i_byte (r_in_byte),
        .o_crc  (crc_next)
    );

    always_comb begin
        n_pos       = (pos == POS_W1_CRC) ? 3'd0 : 3'(pos) + 3'd1;
        n_crc       = r_crc;
        n_pend0     = r_pend0;
        n_pend1     = r_pend1;
        n_first_bad = r_first_bad;
        n_held_co2  = r_held_co2;
        n_held_voc  = r_held_voc;
        n_emit      = 1'b0;
        n_status    = ST_OK;
        unique case (pos)
            POS_W0_HI: begin
                n_crc   = crc_next;
                n_pend0 = {r_in_byte, 8'h00};
            end
            POS_W0_LO: begin
                n_crc   = crc_next;
                n_pend0 = {r_pend0[WORD_W-1:BYTE_W], r_in_byte};
            end
            POS_W0_CRC: begin
                n_first_bad = (r_crc != r_in_byte);
                n_crc       = CRC_INIT;
            end
            POS_W1_HI: begin
                n_crc   = crc_next;
                n_pend1 = {r_in_byte, 8'h00};
            end
            POS_W1_LO: begin
                n_crc   = crc_next;
                n_pend1 = {r_pend1[WORD_W-1:BYTE_W], r_in_byte};
            end
            POS_W1_CRC: begin
                n_emit = 1'b1;
                n_crc  = CRC_INIT;
                if (r_first_bad) begin
                    n_status = ST_FIRST_BAD;
                end else if (r_crc != r_in_byte) begin
                    n_status = ST_SECOND_BAD;
                end else begin
                    n_held_co2 = r_pend0;
                    n_held_voc = r_pend1;
                end
            end
            default: begin
                n_pos = 3'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= 3'd0;
            r_crc       <= CRC_INIT;
            r_pend0     <= '0;
            r_pend1     <= '0;
            r_first_bad <= 1'b0;
            r_held_co2  <= '0;
            r_held_voc  <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= process && n_emit;
            end
            if (process) begin
                r_pos       <= n_pos;
                r_crc       <= n_crc;
                r_pend0     <= n_pend0;
                r_pend1     <= n_pend1;
                r_first_bad <= n_first_bad;
                r_held_co2  <= n_held_co2;
                r_held_voc  <= n_held_voc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_start <= i_s_axis_tuser;
        end
        if (process && n_emit) begin
            r_out_co2    <= n_held_co2;
            r_out_voc    <= n_held_voc;
            r_out_status <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_voc, r_out_co2};
    assign o_m_axis_tuser  = r_out_status;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import swfc_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [15:0]   co2;
        logic [15:0]   voc;
        t_frame_status status;
    } t_reading;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    t_idle_mode idle_mode = IDLE_NONE;
    bit         hold_req  = 1'b0;
    int         hold_left = 0;
    int         quiet_cycles = 0;
    int         fail_count = 0;
    int         bytes_sent = 0;
    int         frames_checked = 0;
    int         status_seen [3];
    bit         aligned = 1'b1;

    // frame tracker state, mirrors the block
    t_byte_pos  cur_pos  = POS_W0_HI;
    logic [7:0] crc_acc  = CRC_INIT;
    logic [15:0] word_a  = '0;
    logic [15:0] word_b  = '0;
    logic        a_bad   = 1'b0;
    logic [15:0] held_co2 = '0;
    logic [15:0] held_voc = '0;
    t_reading    expected_readings [$];

    sensor_word_frame_checker_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] data_byte
        .i_s_axis_tuser  (s_tuser),   // [0] frame_start
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [15:0] co2_equivalent, [31:16] voc_total
        .o_m_axis_tuser  (m_tuser)    // [1:0] frame_status
    );

    always #2 clk = ~clk;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] random_word();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic track_byte(input logic [7:0] b, input logic start);
        t_byte_pos     p;
        t_frame_status st;
        p = start ? POS_W0_HI : cur_pos;
        case (p)
            POS_W0_HI: begin
                crc_acc = crc8_step(CRC_INIT, b);
                word_a  = {b, 8'h00};
            end
            POS_W0_LO: begin
                crc_acc     = crc8_step(crc_acc, b);
                word_a[7:0] = b;
            end
            POS_W0_CRC: begin
                a_bad   = (crc_acc != b);
                crc_acc = CRC_INIT;
            end
            POS_W1_HI: begin
                crc_acc = crc8_step(CRC_INIT, b);
                word_b  = {b, 8'h00};
            end
            POS_W1_LO: begin
                crc_acc     = crc8_step(crc_acc, b);
                word_b[7:0] = b;
            end
            default: begin
                if (a_bad) begin
                    st = ST_FIRST_BAD;
                end else if (crc_acc != b) begin
                    st = ST_SECOND_BAD;
                end else begin
                    st       = ST_OK;
                    held_co2 = word_a;
                    held_voc = word_b;
                end
                crc_acc = CRC_INIT;
                expected_readings.push_back('{co2: held_co2, voc: held_voc, status: st});
            end
        endcase
        cur_pos = (p == POS_W1_CRC) ? POS_W0_HI : t_byte_pos'(p + 1);
    endtask

    always @(posedge clk) begin
        if (rst_n && s_tvalid && s_tready) begin
            track_byte(s_tdata, s_tuser);
        end
    end

    always @(posedge clk) begin
        t_reading exp_r;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected result: co2=%h voc=%h status=%0d",
                         $time, m_tdata[15:0], m_tdata[31:16], m_tuser);
                fail_count++;
            end else begin
                exp_r = expected_readings.pop_front();
                frames_checked++;
                status_seen[exp_r.status]++;
                if (m_tdata[15:0] !== exp_r.co2 || m_tdata[31:16] !== exp_r.voc
                        || m_tuser !== exp_r.status) begin
                    $display("%0t: mismatch exp co2=%h voc=%h st=%0d got co2=%h voc=%h st=%0d",
                             $time, exp_r.co2, exp_r.voc, exp_r.status,
                             m_tdata[15:0], m_tdata[31:16], m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // receiver side: random stalls in the RECV and BOTH idle modes plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (idle_mode == IDLE_RECV) begin
            m_tready <= ($urandom_range(99) >= 49);
        end else if (idle_mode == IDLE_BOTH) begin
            m_tready <= ($urandom_range(99) >= 33);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        int pct;
        pct = (idle_mode == IDLE_SEND) ? 49 : (idle_mode == IDLE_BOTH) ? 33 : 0;
        while ($urandom_range(99) < pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [15:0] wa, input logic [15:0] wb,
                              input bit bad_a, input bit bad_b, input bit mark,
                              input int upto);
        logic [7:0] fb [0:5];
        fb[0] = wa[15:8];
        fb[1] = wa[7:0];
        fb[2] = crc8_step(crc8_step(CRC_INIT, fb[0]), fb[1]);
        fb[3] = wb[15:8];
        fb[4] = wb[7:0];
        fb[5] = crc8_step(crc8_step(CRC_INIT, fb[3]), fb[4]);
        if (bad_a) begin
            fb[2] ^= 8'($urandom_range(1, 255));
        end
        if (bad_b) begin
            fb[5] ^= 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < upto; i++) begin
            send_byte(fb[i], (i == 0) && mark);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        idle_mode = IDLE_NONE;
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1, 6);
        // both CRCs wrong: first failure reported, readings kept
        send_frame(16'h1234, 16'hABCD, 1'b1, 1'b1, 1'b1, 6);
        // partial frame cut by a new start marker
        send_frame(16'h5A5A, 16'hA5A5, 1'b0, 1'b0, 1'b1, 3);
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b1, 1'b1, 6);
        // back-to-back frame with no marker
        send_frame(16'h00FF, 16'hFF00, 1'b0, 1'b0, 1'b0, 6);
        drain();
    endtask

    task automatic test_random(input t_idle_mode mode, input int n_bytes);
        int target;
        int pick;
        idle_mode = mode;
        target = bytes_sent + n_bytes;
        aligned = 1'b1;
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
                send_frame(random_word(), random_word(), $urandom_range(9) < 2,
                           $urandom_range(9) < 2,
                           aligned ? ($urandom_range(3) != 0) : 1'b1, 6);
                aligned = 1'b1;
            end else if (pick < 93) begin
                send_frame(random_word(), random_word(), 1'b0, 1'b0, 1'b1,
                           $urandom_range(1, 5));
                aligned = 1'b0;
            end else begin
                send_byte(8'($urandom), $urandom_range(3) == 0);
                aligned = 1'b0;
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        idle_mode = IDLE_NONE;
        hold_req = 1'b1;
        for (int i = 0; i < 10; i++) begin
            send_frame(random_word(), random_word(), $urandom_range(9) < 2,
                       $urandom_range(9) < 2, 1'b1, 6);
        end
        drain();
    endtask

    task automatic test_sender_pause();
        idle_mode = IDLE_RECV;
        for (int i = 0; i < 6; i++) begin
            send_frame(random_word(), random_word(), 1'b0, $urandom_range(3) == 0,
                       1'b1, 6);
            if (i == 2) begin
                drain();
            end
        end
        drain();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(IDLE_NONE, 280);
        test_random(IDLE_SEND, 280);
        test_random(IDLE_RECV, 280);
        test_random(IDLE_BOTH, 280);
        test_backpressure();
        test_sender_pause();
        $display("Sent %0d bytes under all idle mixes; checked %0d frame results", bytes_sent,
                 frames_checked);
        $display("Status mix: ok=%0d first-word CRC bad=%0d second-word CRC bad=%0d",
                 status_seen[ST_OK], status_seen[ST_FIRST_BAD], status_seen[ST_SECOND_BAD]);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
